@@ rtl/yrgb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV to RGB conversion package
// Shared word types, output formats and fixed-point widths.
// ----------------------------------------------------------------------------
package yrgb_pkg;

	localparam int PROD_W = 18;  // widest product: 454 * (-128) needs 16 bits + sign
	localparam int SUM_W  = 19;  // Y*256 plus products, signed

	localparam logic [2:0] BYTES_PACKED = 3'd3;
	localparam logic [2:0] BYTES_PADDED = 3'd4;

	typedef enum logic [1:0] {
		FMT_RGB24 = 2'd0,
		FMT_BGR24 = 2'd1,
		FMT_RGB32 = 2'd2,
		FMT_BGR32 = 2'd3
	} fmt_t;

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] chroma_blue;
		logic [7:0] luma_second;
		logic [7:0] chroma_red;
		logic       frame_end;
	} yuyv_t;

	typedef struct packed {
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
		logic [7:0] pad_byte;
		logic [2:0] byte_count;
		logic       pair_last;
		logic       frame_last;
	} pixel_t;

	// position marks that ride along with each pixel
	typedef struct packed {
		logic pair_last;
		logic frame_last;
	} tag_t;

	// one pixel at the pipeline entry; chroma already centered on zero
	typedef struct packed {
		logic [7:0]        luma;
		logic signed [7:0] u;
		logic signed [7:0] v;
		tag_t              tag;
	} pix_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] red;
		logic signed [SUM_W-1:0] green;
		logic signed [SUM_W-1:0] blue;
		tag_t                    tag;
	} sums_t;

endpackage

@@ rtl/yrgb_issue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV group issue stage
// Accepts one group and feeds its two pixels into the pipe on consecutive
// cycles; busy covers the cycle of the second pixel.
// ----------------------------------------------------------------------------
module yrgb_issue
	import yrgb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  yuyv_t yuyv,
	output logic  busy,
	output logic  valid_s1,
	output pix_t  pix_s1
);

	logic  pending_q;
	pix_t  hold_q;
	logic  accept;
	logic signed [7:0] u_c;
	logic signed [7:0] v_c;

	assign accept = start && !pending_q;
	assign busy   = pending_q;

	// offset binary minus 128 is just the top bit flipped
	assign u_c = $signed({~yuyv.chroma_blue[7], yuyv.chroma_blue[6:0]});
	assign v_c = $signed({~yuyv.chroma_red[7], yuyv.chroma_red[6:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			pending_q <= accept;
			valid_s1  <= accept || pending_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1.luma           <= yuyv.luma_first;
			pix_s1.u              <= u_c;
			pix_s1.v              <= v_c;
			pix_s1.tag.pair_last  <= 1'b0;
			pix_s1.tag.frame_last <= 1'b0;
			hold_q.luma           <= yuyv.luma_second;
			hold_q.u              <= u_c;
			hold_q.v              <= v_c;
			hold_q.tag.pair_last  <= 1'b1;
			hold_q.tag.frame_last <= yuyv.frame_end;
		end else if (pending_q) begin
			pix_s1 <= hold_q;
		end
	end

endmodule

@@ rtl/yrgb_color.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV to RGB color matrix
// Stage 2 forms the chroma products, stage 3 adds them to the scaled luma.
// ----------------------------------------------------------------------------
module yrgb_color
	import yrgb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_s1,
	input  pix_t  pix_s1,
	output logic  valid_s3,
	output sums_t sums_s3
);

	localparam logic signed [PROD_W-1:0] K_RV = PROD_W'(359);
	localparam logic signed [PROD_W-1:0] K_GU = PROD_W'(88);
	localparam logic signed [PROD_W-1:0] K_GV = PROD_W'(183);
	localparam logic signed [PROD_W-1:0] K_BU = PROD_W'(454);

	logic                     valid_s2;
	logic [7:0]               luma_s2;
	logic signed [PROD_W-1:0] rv_s2;
	logic signed [PROD_W-1:0] gu_s2;
	logic signed [PROD_W-1:0] gv_s2;
	logic signed [PROD_W-1:0] bu_s2;
	tag_t                     tag_s2;
	logic signed [SUM_W-1:0]  yy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		luma_s2 <= pix_s1.luma;
		rv_s2   <= PROD_W'(pix_s1.v) * K_RV;
		gu_s2   <= PROD_W'(pix_s1.u) * K_GU;
		gv_s2   <= PROD_W'(pix_s1.v) * K_GV;
		bu_s2   <= PROD_W'(pix_s1.u) * K_BU;
		tag_s2  <= pix_s1.tag;
	end

	// luma scaled by 256, always non-negative
	assign yy = $signed({(SUM_W-16)'(0), luma_s2, 8'h00});

	always_ff @(posedge clk) begin
		sums_s3.red   <= yy + SUM_W'(rv_s2);
		sums_s3.green <= yy - SUM_W'(gu_s2) - SUM_W'(gv_s2);
		sums_s3.blue  <= yy + SUM_W'(bu_s2);
		sums_s3.tag   <= tag_s2;
	end

endmodule

@@ rtl/yrgb_pack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB byte packer
// Limits each sum to a byte, orders the bytes and registers the output word.
// ----------------------------------------------------------------------------
module yrgb_pack
	import yrgb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  fmt_t  fmt,
	input  logic  valid_s3,
	input  sums_t sums_s3,
	output logic  strobe,
	output pixel_t pixel
);

	function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] x);
		logic [7:0] res;
		if (x > SUM_W'(65535))
			res = 8'hff;
		else if (x <= SUM_W'(255))
			res = 8'h00;
		else
			res = x[15:8];
		return res;
	endfunction

	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	pixel_t     pix_d;

	assign red   = clamp_byte(sums_s3.red);
	assign green = clamp_byte(sums_s3.green);
	assign blue  = clamp_byte(sums_s3.blue);

	always_comb begin
		pix_d.byte_one   = green;
		pix_d.pad_byte   = 8'h00;
		pix_d.pair_last  = sums_s3.tag.pair_last;
		pix_d.frame_last = sums_s3.tag.frame_last;
		unique case (fmt) inside
			FMT_BGR24, FMT_BGR32: begin
				pix_d.byte_zero = blue;
				pix_d.byte_two  = red;
			end
			default: begin
				pix_d.byte_zero = red;
				pix_d.byte_two  = blue;
			end
		endcase
		unique case (fmt) inside
			FMT_RGB32, FMT_BGR32: pix_d.byte_count = BYTES_PADDED;
			default:              pix_d.byte_count = BYTES_PACKED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		pixel <= pix_d;
	end

endmodule

@@ rtl/yuyv_to_rgb_pixel_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV 4:2:2 to RGB pixel converter
// One YUYV group in, two RGB pixels out, format set by a 2-bit register.
// The first pixel passes the issue, product, sum and output registers before it
// strobes, and the second follows. The block takes no new group while busy is high;
// busy is high for the one cycle in which the second pixel enters the pipe.
// Reset clears the pipe valid bits and sets the format to RGB24.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_pixel_converter
	import yrgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  yuyv_t      yuyv,
	output logic       strobe,
	output pixel_t     pixel,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data
);

	fmt_t  fmt_q;
	logic  valid_s1;
	pix_t  pix_s1;
	logic  valid_s3;
	sums_t sums_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB24;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= fmt_t'(cfg_data);
		end
	end

	yrgb_issue u_issue (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.yuyv     (yuyv),
		.busy     (busy),
		.valid_s1 (valid_s1),
		.pix_s1   (pix_s1)
	);

	yrgb_color u_color (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.pix_s1   (pix_s1),
		.valid_s3 (valid_s3),
		.sums_s3  (sums_s3)
	);

	yrgb_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.fmt      (fmt_q),
		.valid_s3 (valid_s3),
		.sums_s3  (sums_s3),
		.strobe   (strobe),
		.pixel    (pixel)
	);

endmodule

@@ rtl/yrgb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV to RGB port checker
// Watches the top-level ports for issue, pairing and output word rules.
// ----------------------------------------------------------------------------
module yrgb_checker
	import yrgb_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   start,
	input logic   busy,
	input logic   strobe,
	input pixel_t pixel
);

	// a group holds the issue port for exactly one extra cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after group accept");

	assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// first pixel of a group appears a fixed time after accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 (strobe && !pixel.pair_last))
		else $error("first pixel missing at expected latency");

	// second pixel always follows the first in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !pixel.pair_last) |=> (strobe && pixel.pair_last))
		else $error("second pixel of pair missing");

	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (pixel.pad_byte == 8'h00 && (!pixel.frame_last || pixel.pair_last)))
		else $error("bad pad byte or frame mark on first pixel");

endmodule

bind yuyv_to_rgb_pixel_converter yrgb_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.pixel  (pixel)
);

@@ bench/yuyv_rgb_pixel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV to RGB pixel checker
// Watches the group, pixel and format channels of the converter, computes
// the two pixels each accepted group should produce and compares every
// strobed pixel, field by field, with the oldest pixel still outstanding.
// ----------------------------------------------------------------------------
module yuyv_rgb_pixel_checker
	import yrgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  yuyv_t      yuyv,
	input  logic       strobe,
	input  pixel_t     pixel,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_data,
	output int         mismatches,
	output int         pending_pixels
);

	fmt_t   out_fmt = FMT_RGB24;
	pixel_t expected_pixels[$];
	int     fail_total = 0;

	// scaled sum back to a byte, saturating at both ends
	function automatic logic [7:0] saturate_byte(input int sum);
		if (sum > 65535)
			return 8'hff;
		if (sum <= 255)
			return 8'h00;
		return sum[15:8];
	endfunction

	function automatic pixel_t convert_pixel(input logic [7:0] luma, input logic [7:0] cb,
		input logic [7:0] cr, input fmt_t fmt, input logic last, input logic frame);
		int         yy;
		int         u;
		int         v;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       bgr;
		logic       wide;
		pixel_t     px;
		yy    = int'(luma) << 8;
		u     = int'(cb) - 128;
		v     = int'(cr) - 128;
		red   = saturate_byte(yy + 359 * v);
		green = saturate_byte(yy - 88 * u - 183 * v);
		blue  = saturate_byte(yy + 454 * u);
		bgr   = (fmt == FMT_BGR24) || (fmt == FMT_BGR32);
		wide  = (fmt == FMT_RGB32) || (fmt == FMT_BGR32);
		px.byte_zero  = bgr ? blue : red;
		px.byte_one   = green;
		px.byte_two   = bgr ? red : blue;
		px.pad_byte   = 8'h00;
		px.byte_count = wide ? BYTES_PADDED : BYTES_PACKED;
		px.pair_last  = last;
		px.frame_last = frame;
		return px;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t want;
		if (!arst_n) begin
			out_fmt = FMT_RGB24;
			expected_pixels.delete();
		end else begin
			if (strobe === 1'b1) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t ns: pixel strobed with none expected, got %h",
						$time, pixel);
					fail_total++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("byte_zero", want.byte_zero, pixel.byte_zero);
					check_field("byte_one", want.byte_one, pixel.byte_one);
					check_field("byte_two", want.byte_two, pixel.byte_two);
					check_field("pad_byte", want.pad_byte, pixel.pad_byte);
					check_field("byte_count", 8'(want.byte_count), 8'(pixel.byte_count));
					check_field("pair_last", 8'(want.pair_last), 8'(pixel.pair_last));
					check_field("frame_last", 8'(want.frame_last), 8'(pixel.frame_last));
				end
			end
			// each accepted group yields its two pixels in order
			if (start && !busy) begin
				expected_pixels.push_back(convert_pixel(yuyv.luma_first, yuyv.chroma_blue,
					yuyv.chroma_red, out_fmt, 1'b0, 1'b0));
				expected_pixels.push_back(convert_pixel(yuyv.luma_second, yuyv.chroma_blue,
					yuyv.chroma_red, out_fmt, 1'b1, yuyv.frame_end));
			end
			if (cfg_valid && cfg_ready)
				out_fmt = fmt_t'(cfg_data);
		end
		mismatches     <= fail_total;
		pending_pixels <= expected_pixels.size();
	end

endmodule

@@ bench/yuyv_to_rgb_pixel_converter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV to RGB pixel converter testbench
// Drives corner-case and random YUYV groups through every output format,
// with random gaps between groups, and lets the pixel checker judge results.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_pixel_converter_tb;
	import yrgb_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_GROUPS  = 200;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	logic       busy;
	yuyv_t      yuyv      = '0;
	logic       strobe;
	pixel_t     pixel;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_data  = '0;
	int         mismatches;
	int         pending_pixels;
	bit         idle_enabled = 1'b1;

	yuyv_to_rgb_pixel_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.yuyv      (yuyv),
		.strobe    (strobe),
		.pixel     (pixel),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	yuyv_rgb_pixel_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.yuyv           (yuyv),
		.strobe         (strobe),
		.pixel          (pixel),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.pending_pixels (pending_pixels)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("yuyv_to_rgb_pixel_converter: mismatch");
		$finish;
	end

	// lean toward the saturation points and the chroma center
	function automatic logic [7:0] pick_sample();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h80;
			3: return 8'($urandom_range(120, 136));
			default: return 8'($urandom);
		endcase
	endfunction

	// hold the word until it is taken; start stays high for the next one
	task automatic send_group(input logic [7:0] y0, input logic [7:0] cb,
		input logic [7:0] y1, input logic [7:0] cr, input logic fe);
		if (idle_enabled && $urandom_range(99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		yuyv  <= '{luma_first: y0, chroma_blue: cb, luma_second: y1, chroma_red: cr,
			frame_end: fe};
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_pixels();
		start <= 1'b0;
		@(posedge clk);
		while (pending_pixels != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_format(input fmt_t fmt);
		cfg_valid <= 1'b1;
		cfg_data  <= fmt;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		fmt_t fmt;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners in the reset format: black, white, gray, saturating chroma
		send_group(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_group(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		send_group(8'd0, 8'd128, 8'd255, 8'd128, 1'b0);
		send_group(8'd255, 8'd128, 8'd0, 8'd128, 1'b1);
		send_group(8'd1, 8'd128, 8'd254, 8'd128, 1'b0);
		send_group(8'd128, 8'd0, 8'd128, 8'd255, 1'b0);
		send_group(8'd128, 8'd255, 8'd128, 8'd0, 1'b0);
		send_group(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
		send_group(8'd1, 8'd1, 8'd254, 8'd254, 1'b1);
		send_group(8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
		send_group(8'd255, 8'd0, 8'd255, 8'd255, 1'b0);
		send_group(8'd255, 8'd129, 8'd255, 8'd129, 1'b0);
		send_group(8'd0, 8'd127, 8'd0, 8'd127, 1'b0);
		send_group(8'd80, 8'd90, 8'd240, 8'd110, 1'b1);
		send_group(8'd81, 8'd240, 8'd41, 8'd34, 1'b0);
		send_group(8'd170, 8'd85, 8'd85, 8'd170, 1'b0);
		send_group(8'd85, 8'd170, 8'd170, 8'd85, 1'b1);
		drain_pixels();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: fmt = FMT_BGR32;
				1: fmt = FMT_BGR24;
				2: fmt = FMT_RGB32;
				3: fmt = FMT_RGB24;
				default: fmt = fmt_t'($urandom_range(3));
			endcase
			write_format(fmt);
			// one phase runs back to back with no gaps
			idle_enabled = (phase != 4);
			for (int k = 0; k < PHASE_GROUPS; k++) begin
				if (phase == 2 && k == PHASE_GROUPS / 2)
					drain_pixels();
				send_group(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
					$urandom_range(9) == 0);
			end
			drain_pixels();
		end

		if (mismatches == 0 && pending_pixels == 0)
			$display("yuyv_to_rgb_pixel_converter: match");
		else
			$display("yuyv_to_rgb_pixel_converter: mismatch");
		$finish;
	end

endmodule
